// ===== src/dq_pkg.sv =====
// Shared constants, types and ring index helper for the double-ended queue.
package dq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int COUNT_W    = $clog2(DEPTH + 1);
	localparam int SUM_W      = COUNT_W + 1;

	localparam logic [1:0] OP_PUSH_RIGHT = 2'd0;
	localparam logic [1:0] OP_POP_LEFT   = 2'd1;
	localparam logic [1:0] OP_POP_RIGHT  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FINISH
	} state_t;

	// Ring position 'off' places right of 'base'; off never exceeds DEPTH.
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
			input logic [COUNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

// ===== src/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/double_ended_queue_core.sv =====
// Double-ended queue on a ring buffer: control, end-value cache and result register.
//
// Input channel (in_valid/in_stall, func, push_value): one operation per
// transaction - push right, pop left or pop right. Code 3 is a no-op.
// Output channel (out_valid/out_stall): exactly one result per operation,
// carrying the popped value, both end values, empty/full flags, the item
// count and a status code (underflow on pop from empty, overflow on push
// to full; state is left untouched in both cases).
// The entries live in one RAM with a registered read. The values
// at both ends are cached in registers, so an operation needs at most one
// RAM read: the neighbour that becomes the new end after a pop.
// Flow: an accepted operation moves to S_FINISH, by way of S_READ when a
// pop leaves two or more items and the new end is read from the RAM.
// Operations do not overlap; in_stall is high while an
// operation is being worked on or its result cannot yet enter the output
// register.
// Reset clears the pointers, the count and the output valid; RAM contents
// are not cleared and are only read after being written.
// A stalled result holds in the output register; the next operation is
// accepted meanwhile but finishes only once that register frees up.
module double_ended_queue_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [dq_pkg::DATA_WIDTH-1:0] push_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dq_pkg::DATA_WIDTH-1:0] popped_value,
	output logic [dq_pkg::DATA_WIDTH-1:0] left_value,
	output logic [dq_pkg::DATA_WIDTH-1:0] right_value,
	output logic                          is_empty_flag,
	output logic                          is_full_flag,
	output logic [dq_pkg::COUNT_W-1:0]    item_count,
	output logic [1:0]                    status
);
	import dq_pkg::*;

	state_t                state_q, state_d;
	logic [IDX_W-1:0]      head_q, head_d;
	logic [COUNT_W-1:0]    count_q, count_d;
	logic [DATA_WIDTH-1:0] left_q, left_d;
	logic [DATA_WIDTH-1:0] right_q, right_d;
	logic [DATA_WIDTH-1:0] popped_q, popped_d;
	logic [1:0]            status_q, status_d;
	logic                  rd_left_q, rd_left_d;
	logic                  out_load;
	logic                  out_valid_q;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [IDX_W-1:0]      ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	logic [DATA_WIDTH-1:0] popped_value_q, left_value_q, right_value_q;
	logic                  empty_q, full_q;
	logic [COUNT_W-1:0]    item_count_q;
	logic [1:0]            status_out_q;

	dq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (push_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		left_d    = left_q;
		right_d   = right_q;
		popped_d  = popped_q;
		status_d  = status_q;
		rd_left_d = rd_left_q;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ring_add(head_q, count_q);
		ram_raddr = ring_add(head_q, COUNT_W'(2));
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					popped_d = '0;
					status_d = ST_OK;
					state_d  = S_FINISH;
					case (func)
						OP_PUSH_RIGHT: begin
							if (count_q == COUNT_W'(DEPTH)) begin
								status_d = ST_OVERFLOW;
							end else begin
								ram_we  = 1'b1;
								right_d = push_value;
								if (count_q == '0) begin
									left_d = push_value;
								end
								count_d = count_q + COUNT_W'(1);
							end
						end
						OP_POP_LEFT: begin
							if (count_q == '0) begin
								status_d = ST_UNDERFLOW;
							end else begin
								popped_d = left_q;
								head_d   = ring_add(head_q, COUNT_W'(1));
								count_d  = count_q - COUNT_W'(1);
								if (count_q == COUNT_W'(2)) begin
									left_d = right_q;
								end else if (count_q > COUNT_W'(2)) begin
									// new left end sits one place right of the popped one
									ram_raddr = ring_add(head_q, COUNT_W'(1));
									rd_left_d = 1'b1;
									state_d   = S_READ;
								end
							end
						end
						OP_POP_RIGHT: begin
							if (count_q == '0) begin
								status_d = ST_UNDERFLOW;
							end else begin
								popped_d = right_q;
								count_d  = count_q - COUNT_W'(1);
								if (count_q == COUNT_W'(2)) begin
									right_d = left_q;
								end else if (count_q > COUNT_W'(2)) begin
									ram_raddr = ring_add(head_q, count_q - COUNT_W'(2));
									rd_left_d = 1'b0;
									state_d   = S_READ;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				if (rd_left_q) begin
					left_d = ram_rdata;
				end else begin
					right_d = ram_rdata;
				end
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		left_q    <= left_d;
		right_q   <= right_d;
		popped_q  <= popped_d;
		status_q  <= status_d;
		rd_left_q <= rd_left_d;
		if (out_load) begin
			popped_value_q <= popped_q;
			left_value_q   <= (count_q != '0) ? left_q : '0;
			right_value_q  <= (count_q != '0) ? right_q : '0;
			empty_q        <= (count_q == '0);
			full_q         <= (count_q == COUNT_W'(DEPTH));
			item_count_q   <= count_q;
			status_out_q   <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign popped_value  = popped_value_q;
	assign left_value    = left_value_q;
	assign right_value   = right_value_q;
	assign is_empty_flag = empty_q;
	assign is_full_flag  = full_q;
	assign item_count    = item_count_q;
	assign status        = status_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("item count above capacity");

	a_read_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_FINISH))
		else $error("RAM read cycle not followed by result cycle");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func == OP_PUSH_RIGHT && count_q != COUNT_W'(DEPTH))
		|=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("push did not grow the queue");

	a_write_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE && in_valid))
		else $error("RAM written outside an accepted push");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OVERFLOW) |-> (is_full_flag && !is_empty_flag))
		else $error("overflow reported while not full");

endmodule

// ===== tb/sv/double_ended_queue_core_tb.sv =====
// Self-checking testbench for the ring-buffer double-ended queue core.
module double_ended_queue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dq_pkg::*;

	// func code 3 is not an operation; the core treats it as a no-op
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int HOLD_CYCLES    = 300;

	typedef struct {
		logic [DATA_WIDTH-1:0] popped;
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
		logic                  empty;
		logic                  full;
		logic [COUNT_W-1:0]    count;
		logic [1:0]            st;
	} deque_result_t;

	class deque_scoreboard;
		logic [DATA_WIDTH-1:0] mirror_ring [DEPTH];
		int                    mirror_head;
		int                    mirror_fill;
		deque_result_t         queued_outcomes [$];
		int                    failures;

		function new();
			mirror_head = 0;
			mirror_fill = 0;
			failures    = 0;
		endfunction

		// Applies an accepted operation to the mirror and queues the outcome.
		function void note_op(input logic [1:0] op, input logic [DATA_WIDTH-1:0] val);
			deque_result_t r;
			r = '{default: '0};
			r.st = ST_OK;
			case (op)
				OP_PUSH_RIGHT: begin
					if (mirror_fill == DEPTH) begin
						r.st = ST_OVERFLOW;
					end else begin
						mirror_ring[(mirror_head + mirror_fill) % DEPTH] = val;
						mirror_fill++;
					end
				end
				OP_POP_LEFT: begin
					if (mirror_fill == 0) begin
						r.st = ST_UNDERFLOW;
					end else begin
						r.popped    = mirror_ring[mirror_head];
						mirror_head = (mirror_head + 1) % DEPTH;
						mirror_fill--;
					end
				end
				OP_POP_RIGHT: begin
					if (mirror_fill == 0) begin
						r.st = ST_UNDERFLOW;
					end else begin
						r.popped = mirror_ring[(mirror_head + mirror_fill - 1) % DEPTH];
						mirror_fill--;
					end
				end
				default: ;
			endcase
			if (mirror_fill != 0) begin
				r.left  = mirror_ring[mirror_head];
				r.right = mirror_ring[(mirror_head + mirror_fill - 1) % DEPTH];
			end
			r.empty = (mirror_fill == 0);
			r.full  = (mirror_fill == DEPTH);
			r.count = COUNT_W'(mirror_fill);
			queued_outcomes.insert(queued_outcomes.size(), r);
		endfunction

		function void compare_field(input string field, input logic [DATA_WIDTH-1:0] want,
				input logic [DATA_WIDTH-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h, got %h", $time, field, want, got);
				failures++;
			end
		endfunction

		function void check_result(input deque_result_t got);
			deque_result_t want;
			if (queued_outcomes.size() == 0) begin
				$display("%0t: result with nothing outstanding, expected none, got popped %h",
					$time, got.popped);
				failures++;
				return;
			end
			want = queued_outcomes.pop_front();
			compare_field("popped_value", want.popped, got.popped);
			compare_field("left_value", want.left, got.left);
			compare_field("right_value", want.right, got.right);
			compare_field("is_empty_flag", DATA_WIDTH'(want.empty), DATA_WIDTH'(got.empty));
			compare_field("is_full_flag", DATA_WIDTH'(want.full), DATA_WIDTH'(got.full));
			compare_field("item_count", DATA_WIDTH'(want.count), DATA_WIDTH'(got.count));
			compare_field("status", DATA_WIDTH'(want.st), DATA_WIDTH'(got.st));
		endfunction

		function int outstanding();
			return queued_outcomes.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            func;
	logic [DATA_WIDTH-1:0] push_value;
	logic                  out_valid;
	logic                  out_stall;
	logic [DATA_WIDTH-1:0] popped_value;
	logic [DATA_WIDTH-1:0] left_value;
	logic [DATA_WIDTH-1:0] right_value;
	logic                  is_empty_flag;
	logic                  is_full_flag;
	logic [COUNT_W-1:0]    item_count;
	logic [1:0]            status;

	deque_scoreboard sb;
	deque_result_t   seen;
	int              send_idle_pct;
	int              recv_stall_pct;
	bit              hold_request;

	double_ended_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.left_value   (left_value),
		.right_value  (right_value),
		.is_empty_flag(is_empty_flag),
		.is_full_flag (is_full_flag),
		.item_count   (item_count),
		.status       (status)
	);

	always #5 clk = ~clk;

	// Offers one transaction, with random idle cycles ahead of it.
	task automatic send_op(input logic [1:0] op, input logic [DATA_WIDTH-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= op;
		push_value <= val;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_op(op, val);
	endtask

	function automatic logic [1:0] pick_op(input int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < 4) begin
			return OP_NOP;
		end else if (r < 4 + push_pct) begin
			return OP_PUSH_RIGHT;
		end else if ($urandom_range(1) == 0) begin
			return OP_POP_LEFT;
		end
		return OP_POP_RIGHT;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_value();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Push bias is re-picked at random every burst so the queue swings between empty and full.
	task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
		int bias;
		bias           = 50;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: bias = 85;
					1: bias = 15;
					default: bias = 50;
				endcase
			end
			send_op(pick_op(bias), pick_value());
		end
	endtask

	// Receiver: random stalls, or a long hold-off counted here when requested.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.popped = popped_value;
			seen.left   = left_value;
			seen.right  = right_value;
			seen.empty  = is_empty_flag;
			seen.full   = is_full_flag;
			seen.count  = item_count;
			seen.st     = status;
			sb.check_result(seen);
		end
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		sb             = new();
		in_valid       = 1'b0;
		func           = OP_NOP;
		push_value     = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: both pops underflow, no-op reports empty
		send_op(OP_POP_LEFT, '1);
		send_op(OP_POP_RIGHT, '0);
		send_op(OP_NOP, 32'hDEAD_BEEF);
		// fill to the brim, then overflow and a no-op on full, then pop from each end
		send_op(OP_PUSH_RIGHT, '0);
		send_op(OP_PUSH_RIGHT, '1);
		send_op(OP_PUSH_RIGHT, 32'h8000_0001);
		for (int i = 3; i < DEPTH; i++) begin
			send_op(OP_PUSH_RIGHT, {16'hA5C3, 16'(i)});
		end
		send_op(OP_PUSH_RIGHT, 32'h1234_5678);
		send_op(OP_NOP, '1);
		send_op(OP_POP_LEFT, '0);
		send_op(OP_POP_RIGHT, '0);

		run_phase(0, 0, 340);
		run_phase(55, 0, 340);
		run_phase(0, 55, 340);
		run_phase(27, 27, 340);

		// long receiver hold-off while items keep coming, so the input backs up
		hold_request = 1'b1;
		run_phase(0, 0, 48);

		in_valid       <= 1'b0;
		recv_stall_pct = 0;
		while (sb.outstanding() > 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (sb.failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
